### rtl/core/srle_pkg.sv
package srle_pkg;

  // One input request: a channel sample and its segment markers.
  typedef struct packed {
    logic [7:0] sample_value;
    logic       first_sample;
    logic       last_sample;
  } sample_t;

  // Token kinds.
  localparam logic KIND_LITERAL = 1'b0;
  localparam logic KIND_REPEAT  = 1'b1;

  // One result request: a literal stretch or a repeat run.
  typedef struct packed {
    logic        token_kind;
    logic [9:0]  start_position;
    logic [10:0] sample_count;
    logic [7:0]  run_value;
    logic        last_of_item;
  } token_t;

  // Tokens produced by one sample: zero, one or two.
  typedef struct packed {
    logic [1:0] num_tokens;
    token_t     tok0;
    token_t     tok1;
  } token_pair_t;

  // Run detector states.
  typedef enum logic [2:0] {
    MODE_DATA = 3'b001,
    MODE_TWO  = 3'b010,
    MODE_RUN  = 3'b100
  } detect_mode_t;

  // Output queue geometry.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = 2;

endpackage

### rtl/core/srle_encode.sv
module srle_encode
  import srle_pkg::*;
#(
  parameter int unsigned MAX_SEGMENT_LENGTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        advance,
  input  sample_t     sample,
  output token_pair_t tokens
);

  localparam int unsigned PW = $clog2(MAX_SEGMENT_LENGTH + 1);
  localparam logic [PW-1:0] MAX_POS = PW'(MAX_SEGMENT_LENGTH);

  detect_mode_t  mode_r, mode_nxt;
  logic [7:0]    cand_value_r, cand_value_nxt;
  logic [PW-1:0] cand_start_r, cand_start_nxt;
  logic [PW-1:0] lit_start_r, lit_start_nxt;
  logic [PW-1:0] pos_r, pos_nxt;

  logic          mid_valid;
  token_t        mid_tok;
  token_t        flush_tok;
  logic [PW-1:0] flush_len;

  always_comb begin
    mode_nxt       = mode_r;
    cand_value_nxt = cand_value_r;
    cand_start_nxt = cand_start_r;
    lit_start_nxt  = lit_start_r;
    pos_nxt        = pos_r;
    mid_valid      = 1'b0;
    mid_tok        = '0;

    if (sample.first_sample || pos_r == '0) begin
      mode_nxt       = MODE_DATA;
      cand_value_nxt = sample.sample_value;
      cand_start_nxt = '0;
      lit_start_nxt  = '0;
      pos_nxt        = PW'(1);
    end else if (pos_r < MAX_POS) begin
      case (mode_r)
        MODE_DATA: begin
          if (sample.sample_value == cand_value_r) begin
            mode_nxt = MODE_TWO;
          end else begin
            cand_value_nxt = sample.sample_value;
            cand_start_nxt = pos_r;
          end
        end
        MODE_TWO: begin
          if (sample.sample_value == cand_value_r) begin
            mode_nxt = MODE_RUN;
            // The literal stretch ahead of the new run is closed now.
            if (cand_start_r > lit_start_r) begin
              mid_valid              = 1'b1;
              mid_tok.token_kind     = KIND_LITERAL;
              mid_tok.start_position = 10'(lit_start_r);
              mid_tok.sample_count   = 11'(cand_start_r - lit_start_r);
            end
          end else begin
            mode_nxt       = MODE_DATA;
            cand_value_nxt = sample.sample_value;
            cand_start_nxt = pos_r;
          end
        end
        default: begin
          if (sample.sample_value != cand_value_r) begin
            mid_valid              = 1'b1;
            mid_tok.token_kind     = KIND_REPEAT;
            mid_tok.start_position = 10'(cand_start_r);
            mid_tok.sample_count   = 11'(pos_r - cand_start_r);
            mid_tok.run_value      = cand_value_r;
            mode_nxt               = MODE_DATA;
            cand_value_nxt         = sample.sample_value;
            cand_start_nxt         = pos_r;
            lit_start_nxt          = pos_r;
          end
        end
      endcase
      pos_nxt = pos_r + PW'(1);
    end

    // Flush token, built from the state after this sample.
    flush_tok = '0;
    flush_tok.last_of_item = 1'b1;
    if (mode_nxt == MODE_RUN) begin
      flush_len                = pos_nxt - cand_start_nxt;
      flush_tok.token_kind     = KIND_REPEAT;
      flush_tok.start_position = 10'(cand_start_nxt);
      flush_tok.run_value      = cand_value_nxt;
    end else begin
      flush_len                = pos_nxt - lit_start_nxt;
      flush_tok.token_kind     = KIND_LITERAL;
      flush_tok.start_position = 10'(lit_start_nxt);
    end
    flush_tok.sample_count = 11'(flush_len);

    if (sample.last_sample) begin
      mode_nxt = MODE_DATA;
      pos_nxt  = '0;
    end

    tokens = '0;
    if (mid_valid) begin
      tokens.tok0              = mid_tok;
      tokens.tok0.last_of_item = !sample.last_sample;
      tokens.tok1              = flush_tok;
      tokens.num_tokens        = sample.last_sample ? 2'd2 : 2'd1;
    end else begin
      tokens.tok0       = flush_tok;
      tokens.num_tokens = sample.last_sample ? 2'd1 : 2'd0;
    end
    if (!advance) begin
      tokens.num_tokens = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_DATA;
      cand_value_r <= '0;
      cand_start_r <= '0;
      lit_start_r  <= '0;
      pos_r        <= '0;
    end else if (advance) begin
      mode_r       <= mode_nxt;
      cand_value_r <= cand_value_nxt;
      cand_start_r <= cand_start_nxt;
      lit_start_r  <= lit_start_nxt;
      pos_r        <= pos_nxt;
    end
  end

endmodule

### rtl/core/srle_token_queue.sv
module srle_token_queue
  import srle_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  token_pair_t push,
  output logic        room_for_two,
  output logic        out_valid,
  input  logic        out_stall,
  output token_t      out_data
);

  token_t              entry_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_AW:0]   count_r, count_nxt;
  logic                pop;

  assign out_valid    = (count_r != '0);
  assign out_data     = entry_r[rd_ptr_r];
  assign pop          = out_valid && !out_stall;
  assign room_for_two = (count_r <= (QUEUE_AW + 1)'(QUEUE_DEPTH - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QUEUE_AW'(push.num_tokens);
    rd_ptr_nxt = rd_ptr_r + QUEUE_AW'(pop);
    count_nxt  = count_r + (QUEUE_AW + 1)'(push.num_tokens) - (QUEUE_AW + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.num_tokens != 2'd0) begin
      entry_r[wr_ptr_r] <= push.tok0;
    end
    if (push.num_tokens == 2'd2) begin
      entry_r[wr_ptr_r + QUEUE_AW'(1)] <= push.tok1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

### rtl/core/segment_run_length_encoder.sv
// Segment run-length encoder with a minimum run of three samples.
//
// Input channel (in_valid / in_stall / in_data): one channel byte per request,
// with flags that mark the first and the last sample of a segment. A request
// is taken at a rising edge where in_valid is high and in_stall is low.
// Output channel (out_valid / out_stall / out_data): literal and repeat tokens
// in segment order. A sample gives zero, one or two tokens; last_of_item marks
// the final token that a sample produced.
//
// A token reaches the output through the input register, which holds the sample
// that caused it, and then through the token queue.
// Throughput: one sample per cycle while the queue has room. The input register
// is processed only when the four-entry token queue has room for two tokens, so
// the extra token of a two-token sample is absorbed by the queue while samples
// keep flowing.
//
// Reset (synchronous, active low) closes any open segment, empties the queue
// and marks the input register empty. When the receiver stalls, the queue fills,
// in_stall rises, and the waiting token holds steady on out_data.
module segment_run_length_encoder
  import srle_pkg::*;
#(
  parameter int unsigned MAX_SEGMENT_LENGTH = 1024
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  sample_t in_data,
  output logic    out_valid,
  input  logic    out_stall,
  output token_t  out_data
);

  logic        s1_valid_r;
  sample_t     s1_data_r;
  logic        room_for_two;
  logic        advance;
  token_pair_t tokens;

  // The held sample is encoded once the queue can take both possible tokens.
  assign advance  = s1_valid_r && room_for_two;
  assign in_stall = s1_valid_r && !room_for_two;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r <= in_data;
    end
  end

  srle_encode #(
    .MAX_SEGMENT_LENGTH(MAX_SEGMENT_LENGTH)
  ) u_encode (
    .clk    (clk),
    .rst_n  (rst_n),
    .advance(advance),
    .sample (s1_data_r),
    .tokens (tokens)
  );

  srle_token_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (tokens),
    .room_for_two(room_for_two),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

### rtl/core/srle_checker.sv
module srle_checker
  import srle_pkg::*;
(
  input logic    clk,
  input logic    rst_n,
  input logic    in_valid,
  input logic    in_stall,
  input sample_t in_data,
  input logic    out_valid,
  input logic    out_stall,
  input token_t  out_data
);

  // A stalled token stays put.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled token changed");

  // A stalled sample request stays put until the block takes it.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled sample changed");

  // Reset leaves no token pending.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("token present after reset");

  // Literal tokens never carry a value.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.token_kind == KIND_LITERAL |-> out_data.run_value == 8'd0)
    else $error("literal token with nonzero value");

  // Both tokens of a two-token sample are queued together, so the second is
  // ready right after the first leaves.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last_of_item |=> out_valid)
    else $error("second token of a sample missing");

endmodule

bind segment_run_length_encoder srle_checker u_srle_checker (.*);
